// File: rtl/sgm_pkg.sv
// Package for the Sobel gradient magnitude block: widths, register indexes,
// reset values and the command/status structs between controller and datapath.
// No dependencies.
package sgm_pkg;

  localparam int unsigned MaxLine  = 1024;
  localparam int unsigned PixW     = 8;
  localparam int unsigned ColW     = $clog2(MaxLine);
  localparam int unsigned LenW     = 11;
  localparam int unsigned RowW     = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned AbsW     = 10;
  localparam int unsigned SqW      = 2 * AbsW;
  localparam int unsigned SumW     = SqW + 1;
  localparam int unsigned RadW     = 16;
  localparam int unsigned RemW     = 11;
  localparam int unsigned StepW    = 3;

  localparam logic [CfgIdxW-1:0] CfgLineLength = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgLineCount  = 1'b1;

  localparam logic [LenW-1:0] LineLengthRst = LenW'(640);
  localparam logic [RowW-1:0] LineCountRst  = RowW'(480);
  localparam logic [PixW-1:0] MagMax        = '1;

  typedef struct packed {
    logic accept;     // latch request pixel, read line stores
    logic shift;      // shift window, write line stores, advance position
    logic grad;       // form |Gx|, |Gy|
    logic square;     // square both gradients
    logic root_init;  // load root unit
    logic root_step;  // one root digit
    logic emit;       // load output register
  } sgm_cmd_t;

  typedef struct packed {
    logic interior;
    logic root_last;
    logic out_busy;
  } sgm_sts_t;

endpackage

// File: rtl/sgm_stream_if.sv
// Request channels of the Sobel block: pixel input and magnitude output.
// Depends on sgm_pkg.
interface sgm_pix_if
  import sgm_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface sgm_mag_if
  import sgm_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] magnitude;
  logic            line_end;
  logic            frame_end;

  modport source (output valid, output magnitude, output line_end, output frame_end,
                  input ready);
  modport sink   (input valid, input magnitude, input line_end, input frame_end,
                  output ready);
endinterface

// File: rtl/sgm_ctrl.sv
// Controller of the Sobel block: sequences one pixel request through the
// datapath. Depends on sgm_pkg.
module sgm_ctrl
  import sgm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  sgm_sts_t sts_i,
  output sgm_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StShift  = 7'b0000010,
    StGrad   = 7'b0000100,
    StSquare = 7'b0001000,
    StRInit  = 7'b0010000,
    StRoot   = 7'b0100000,
    StEmit   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) state_d = StShift;
      end
      StShift: begin
        cmd_o.shift = 1'b1;
        state_d     = sts_i.interior ? StGrad : StIdle;
      end
      StGrad: begin
        cmd_o.grad = 1'b1;
        state_d    = StSquare;
      end
      StSquare: begin
        cmd_o.square = 1'b1;
        state_d      = StRInit;
      end
      StRInit: begin
        cmd_o.root_init = 1'b1;
        state_d         = StRoot;
      end
      StRoot: begin
        cmd_o.root_step = 1'b1;
        if (sts_i.root_last) state_d = StEmit;
      end
      StEmit: begin
        cmd_o.emit = !sts_i.out_busy;
        if (!sts_i.out_busy) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/sgm_datapath.sv
// Datapath of the Sobel block: config registers, line stores, 3x3 window,
// gradients, squares, digit-serial square root and output register.
// Depends on sgm_pkg.
module sgm_datapath
  import sgm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [PixW-1:0]     pixel_i,
  input  sgm_cmd_t            cmd_i,
  output sgm_sts_t            sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PixW-1:0]     magnitude_o,
  output logic                line_end_o,
  output logic                frame_end_o
);

  logic [LenW-1:0] len_q;
  logic [RowW-1:0] cnt_q;
  logic [LenW-1:0] len_eff;
  logic [RowW-1:0] cnt_eff;
  logic [ColW-1:0] len_m1;
  logic [RowW-1:0] cnt_m1;

  always_comb begin
    if (len_q < LenW'(3)) len_eff = LenW'(3);
    else if (len_q > LenW'(MaxLine)) len_eff = LenW'(MaxLine);
    else len_eff = len_q;
    cnt_eff = (cnt_q < RowW'(3)) ? RowW'(3) : cnt_q;
    len_m1  = ColW'(len_eff - LenW'(1));
    cnt_m1  = cnt_eff - RowW'(1);
  end

  // Position of the next pixel, clamped to the current frame shape.
  logic [ColW-1:0] col_q, col_d, cur_col_q, col_clamp;
  logic [RowW-1:0] row_q, row_d, cur_row_q, row_clamp;
  logic            last_col_q, last_row_q;

  assign col_clamp = ({1'b0, col_q} >= len_eff) ? len_m1 : col_q;
  assign row_clamp = (row_q >= cnt_eff) ? cnt_m1 : row_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (cmd_i.shift) begin
      if (last_col_q) begin
        col_d = '0;
        row_d = last_row_q ? '0 : cur_row_q + RowW'(1);
      end else begin
        col_d = cur_col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LineLengthRst;
      cnt_q <= LineCountRst;
      col_q <= '0;
      row_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgLineLength: len_q <= cfg_data_i[LenW-1:0];
          CfgLineCount:  cnt_q <= cfg_data_i[RowW-1:0];
          default: ;
        endcase
      end
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line stores
  logic [PixW-1:0] upper_mem [MaxLine];
  logic [PixW-1:0] middle_mem [MaxLine];
  logic [PixW-1:0] up_rd_q, mid_rd_q, px_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      up_rd_q    <= upper_mem[col_clamp];
      mid_rd_q   <= middle_mem[col_clamp];
      px_q       <= pixel_i;
      cur_col_q  <= col_clamp;
      cur_row_q  <= row_clamp;
      last_col_q <= (col_clamp == len_m1);
      last_row_q <= (row_clamp == cnt_m1);
    end
    if (cmd_i.shift) begin
      upper_mem[cur_col_q]  <= mid_rd_q;
      middle_mem[cur_col_q] <= px_q;
    end
  end

  // 3x3 window, rows top to bottom, oldest column first
  logic [PixW-1:0] win_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) win_q[k] <= '0;
    end else if (cmd_i.shift) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k*3]   <= win_q[k*3+1];
        win_q[k*3+1] <= win_q[k*3+2];
      end
      win_q[2] <= up_rd_q;
      win_q[5] <= mid_rd_q;
      win_q[8] <= px_q;
    end
  end

  assign sts_o.interior = (cur_col_q >= ColW'(2)) && (cur_row_q >= RowW'(2));

  // Gradients
  logic [AbsW-1:0] pos_x, neg_x, pos_y, neg_y, abs_x, abs_y;
  logic [AbsW-1:0] abs_x_q, abs_y_q;
  logic [SqW-1:0]  sq_x_q, sq_y_q;
  logic [SumW-1:0] sum;

  always_comb begin
    pos_x = AbsW'(win_q[2]) + {1'b0, win_q[5], 1'b0} + AbsW'(win_q[8]);
    neg_x = AbsW'(win_q[0]) + {1'b0, win_q[3], 1'b0} + AbsW'(win_q[6]);
    pos_y = AbsW'(win_q[6]) + {1'b0, win_q[7], 1'b0} + AbsW'(win_q[8]);
    neg_y = AbsW'(win_q[0]) + {1'b0, win_q[1], 1'b0} + AbsW'(win_q[2]);
    abs_x = (pos_x >= neg_x) ? pos_x - neg_x : neg_x - pos_x;
    abs_y = (pos_y >= neg_y) ? pos_y - neg_y : neg_y - pos_y;
    sum   = SumW'(sq_x_q) + SumW'(sq_y_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.grad) begin
      abs_x_q <= abs_x;
      abs_y_q <= abs_y;
    end
    if (cmd_i.square) begin
      sq_x_q <= abs_x_q * abs_x_q;
      sq_y_q <= abs_y_q * abs_y_q;
    end
  end

  // Square root, two radicand bits per step
  logic [RadW-1:0]  rad_q;
  logic [RemW-1:0]  rem_q, rem_sh, trial;
  logic [PixW-1:0]  root_q;
  logic [StepW-1:0] step_q;
  logic             sat_q;

  assign rem_sh = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign sts_o.root_last = (step_q == '1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_init) begin
      rad_q  <= sum[RadW-1:0];
      sat_q  <= |sum[SumW-1:RadW];
      rem_q  <= '0;
      root_q <= '0;
      step_q <= '0;
    end else if (cmd_i.root_step) begin
      rad_q  <= {rad_q[RadW-3:0], 2'b00};
      step_q <= step_q + StepW'(1);
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[PixW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[PixW-2:0], 1'b0};
      end
    end
  end

  // Output register
  logic            out_valid_q;
  logic [PixW-1:0] mag_q;
  logic            line_end_q, frame_end_q;

  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      mag_q       <= sat_q ? MagMax : root_q;
      line_end_q  <= last_col_q;
      frame_end_q <= last_col_q && last_row_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign magnitude_o = mag_q;
  assign line_end_o  = line_end_q;
  assign frame_end_o = frame_end_q;

endmodule

// File: rtl/sobel_gradient_magnitude.sv
// Streaming 3x3 Sobel gradient magnitude, one gray pixel per request in raster
// order. A pixel on the top two rows or left two columns gives no result and
// goes only through the line store read and window shift; any other pixel goes
// on to gradients, squares, root load and the two-bit-per-cycle square root,
// then the output register load. The output register lets a new pixel enter
// while a result waits. Config writes restart the frame at the next pixel.
// Depends on sgm_pkg, sgm_stream_if, sgm_ctrl and sgm_datapath.
module sobel_gradient_magnitude
  import sgm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  sgm_pix_if.sink             pix_i,
  sgm_mag_if.source           mag_o
);

  sgm_cmd_t cmd;
  sgm_sts_t sts;

  sgm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .in_ready_o (pix_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sgm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pixel_i     (pix_i.pixel),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (mag_o.valid),
    .out_ready_i (mag_o.ready),
    .magnitude_o (mag_o.magnitude),
    .line_end_o  (mag_o.line_end),
    .frame_end_o (mag_o.frame_end)
  );

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for sobel_gradient_magnitude: streams gray frames of several
// geometries and checks each magnitude and its flags against an in-bench Sobel model.
// Depends on sgm_pkg, the sgm_pix_if / sgm_mag_if interfaces and the block's RTL.
module tb;
  import sgm_pkg::*;

  localparam int unsigned ClkPeriod    = 10;
  localparam int unsigned RstCycles    = 8;
  localparam int unsigned DrainCycles  = 32;
  localparam int unsigned RandomPixels = 790;
  localparam int unsigned CycleLimit   = 2_000_000;

  typedef enum int {
    PixUniform,
    PixLowContrast,
    PixBinary
  } pix_style_e;

  typedef struct packed {
    logic [PixW-1:0] magnitude;
    logic            line_end;
    logic            frame_end;
  } mag_item_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  sgm_pix_if pix_if ();
  sgm_mag_if mag_if ();

  sobel_gradient_magnitude i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_if),
    .mag_o      (mag_if)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Sobel model state
  bit [PixW-1:0]   upper_line  [MaxLine];
  bit [PixW-1:0]   middle_line [MaxLine];
  int              window_px   [9];
  int unsigned     col_pos = 0;
  int unsigned     row_pos = 0;
  logic [LenW-1:0] line_length_reg = LineLengthRst;
  logic [RowW-1:0] line_count_reg  = LineCountRst;
  mag_item_t       mag_expected_q [$];

  bit          src_idle_en  = 1'b0;
  bit          sink_idle_en = 1'b0;
  int unsigned hold_cycles  = 0;
  int unsigned error_count    = 0;
  int unsigned pixels_sent    = 0;
  int unsigned mags_checked   = 0;
  int unsigned frame_settings = 0;

  function automatic logic [PixW-1:0] floor_root_sat(input int unsigned v);
    int unsigned root;
    root = 0;
    if (v >= 65536) return MagMax;
    for (int unsigned b = 128; b != 0; b >>= 1) begin
      if ((root | b) * (root | b) <= v) root |= b;
    end
    return PixW'(root);
  endfunction

  function automatic void sobel_step(input logic [PixW-1:0] px);
    int unsigned len, cnt, c, r;
    int          gx, gy;
    mag_item_t   item;
    len = (line_length_reg < 3) ? 3 : (line_length_reg > MaxLine) ? MaxLine : line_length_reg;
    cnt = (line_count_reg < 3) ? 3 : line_count_reg;
    c = (col_pos < len) ? col_pos : len - 1;
    r = (row_pos < cnt) ? row_pos : cnt - 1;
    for (int k = 0; k < 3; k++) begin
      window_px[3*k]   = window_px[3*k+1];
      window_px[3*k+1] = window_px[3*k+2];
    end
    window_px[2] = upper_line[c];
    window_px[5] = middle_line[c];
    window_px[8] = px;
    upper_line[c]  = middle_line[c];
    middle_line[c] = px;
    if (c >= 2 && r >= 2) begin
      gx = window_px[2] + 2 * window_px[5] + window_px[8]
         - window_px[0] - 2 * window_px[3] - window_px[6];
      gy = window_px[6] + 2 * window_px[7] + window_px[8]
         - window_px[0] - 2 * window_px[1] - window_px[2];
      item.magnitude = floor_root_sat(gx * gx + gy * gy);
      item.line_end  = (c == len - 1);
      item.frame_end = item.line_end && (r == cnt - 1);
      mag_expected_q.push_back(item);
    end
    if (c == len - 1) begin
      col_pos = 0;
      row_pos = (r == cnt - 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [PixW-1:0] gen_pixel(input pix_style_e style, input int unsigned base);
    case (style)
      PixLowContrast: return PixW'(base + $urandom_range(0, 15));
      PixBinary:      return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      default:        return PixW'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(input logic [PixW-1:0] px);
    int unsigned gap;
    gap = src_idle_en ? pick_gap() : 0;
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= px;
    do @(posedge clk_i); while (!pix_if.ready);
    sobel_step(px);
    pixels_sent++;
  endtask

  // border pixels leave the block busy after the last result
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    while (mag_expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CfgDataW'(value);
    @(posedge clk_i);
    if (idx == CfgLineLength) begin
      line_length_reg = LenW'(value);
    end else begin
      line_count_reg = RowW'(value);
    end
    col_pos = 0;
    row_pos = 0;
  endtask

  task automatic set_frame(input int unsigned len_w, input int unsigned cnt_w);
    wait_idle();
    write_reg(CfgLineLength, len_w);
    write_reg(CfgLineCount, cnt_w);
    cfg_we_i <= 1'b0;
    frame_settings++;
  endtask

  // short line and frame clamp to 3x3, saturation, then frame wrap
  task automatic test_short_frame();
    logic [PixW-1:0] step_edge [9];
    step_edge = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF};
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    set_frame(0, 0);
    foreach (step_edge[k]) send_pixel(step_edge[k]);
    repeat (9) send_pixel(8'hFF);
  endtask

  // ramp window: non-square sum, floor of root
  task automatic test_mid_gradients();
    set_frame(2, 1);
    for (int k = 0; k < 9; k++) send_pixel(PixW'(k));
  endtask

  task automatic test_backpressure();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    set_frame(5, 4);
    hold_cycles = 300;
    repeat (20) send_pixel(gen_pixel(PixUniform, 0));
  endtask

  task automatic test_random_frames();
    int unsigned len_w, cnt_w, len_e, rows, n, base, sent;
    pix_style_e  style;
    sent = 0;
    while (sent < RandomPixels) begin
      len_w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 16);
      case ($urandom_range(0, 7))
        0:       cnt_w = $urandom_range(0, 2);
        1:       cnt_w = 65535;
        default: cnt_w = $urandom_range(3, 6);
      endcase
      len_e = (len_w < 3) ? 3 : len_w;
      rows  = (cnt_w < 3) ? 3 : (cnt_w > 6) ? 4 : cnt_w;
      n     = $urandom_range(2 * len_e + 1, (rows + 2) * len_e);
      style = pix_style_e'($urandom_range(0, 2));
      base  = $urandom_range(0, 240);
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      set_frame(len_w, cnt_w);
      repeat (n) begin
        send_pixel(gen_pixel(style, base));
        sent++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    mag_item_t want;
    if (rst_ni && mag_if.valid && mag_if.ready) begin
      if (mag_expected_q.size() == 0) begin
        $error("magnitude: none expected, got %0d", mag_if.magnitude);
        error_count++;
      end else begin
        want = mag_expected_q.pop_front();
        if (mag_if.magnitude !== want.magnitude) begin
          $error("magnitude: expected %0d, got %0d", want.magnitude, mag_if.magnitude);
          error_count++;
        end
        if (mag_if.line_end !== want.line_end) begin
          $error("line_end: expected %0b, got %0b", want.line_end, mag_if.line_end);
          error_count++;
        end
        if (mag_if.frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, mag_if.frame_end);
          error_count++;
        end
        mags_checked++;
      end
    end
  end

  initial begin : sink_ctrl
    int unsigned stall_left;
    stall_left = 0;
    mag_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        mag_if.ready <= 1'b0;
      end else begin
        if (stall_left == 0 && sink_idle_en && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        if (stall_left != 0) begin
          stall_left--;
          mag_if.ready <= 1'b0;
        end else begin
          mag_if.ready <= 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d magnitudes outstanding", cycles,
             mag_expected_q.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= CfgLineLength;
    cfg_data_i   <= '0;
    pix_if.valid <= 1'b0;
    pix_if.pixel <= '0;
    repeat (RstCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_short_frame();
    test_mid_gradients();
    test_backpressure();
    test_random_frames();
    wait_idle();

    $display("%0d pixels over %0d frame geometries, %0d magnitudes checked", pixels_sent,
             frame_settings, mags_checked);
    $display("clamped sizes, frame wrap, saturation and output back-pressure");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/sgm_pkg.sv
rtl/sgm_stream_if.sv
rtl/sgm_ctrl.sv
rtl/sgm_datapath.sv
rtl/sobel_gradient_magnitude.sv
verif/tb.sv
